// ===== rtl/btm_pkg.sv =====
// ----------------------------------------------------------------------------
// btm_pkg
// Shared types, sizes and codes of the two-symbol Turing machine step core.
// ----------------------------------------------------------------------------
package btm_pkg;

  localparam int NUM_STATES = 64;
  localparam int TAPE_LEN   = 4096;

  // Field widths of the request and response transactions
  localparam int REQ_W   = 3;
  localparam int STATE_W = 6;
  localparam int MOVE_W  = 2;
  localparam int CELL_W  = 12;
  localparam int STAT_W  = 2;

  // Storage index widths
  localparam int STATE_AW  = $clog2(NUM_STATES);
  localparam int RULE_AW   = STATE_AW + 1;
  localparam int NUM_RULES = 2 * NUM_STATES;
  localparam int TAPE_AW   = $clog2(TAPE_LEN);

  localparam logic [CELL_W-1:0] HEAD_START_RST = CELL_W'(2048);

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD     = 3'd0,
    REQ_WRITE   = 3'd1,
    REQ_STEP    = 3'd2,
    REQ_READ    = 3'd3,
    REQ_RESTART = 3'd4
  } req_code_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_HALT = 2'd2,
    ST_EDGE = 2'd3
  } status_code_t;

  localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd0;
  localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [STATE_W-1:0] from_state;
    logic               match_symbol;
    logic               write_symbol;
    logic [MOVE_W-1:0]  move_dir;
    logic [STATE_W-1:0] to_state;
    logic [CELL_W-1:0]  cell_address;
    logic               cell_value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [STATE_W-1:0] current_state;
    logic [CELL_W-1:0]  head_position;
    logic               seen_symbol;
    logic               is_halted;
  } rsp_t;

  // Datapath phase selected by the controller
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CLEAR,
    PH_CAPTURE,
    PH_EXEC,
    PH_RULE,
    PH_STEP
  } phase_t;

  typedef struct packed {
    phase_t phase;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic halted;
  } dp_stat_t;

endpackage

// ===== rtl/btm_ctrl.sv =====
// ----------------------------------------------------------------------------
// btm_ctrl
// Sequencer: tape clearing pass after reset, then one transaction at a time.
// ----------------------------------------------------------------------------
module btm_ctrl
  import btm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [REQ_W-1:0] req_type,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd,
  output logic             busy
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RULE,
    S_STEP
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.phase  = PH_IDLE;
    case (state)
      S_CLEAR: begin
        cmd.phase = PH_CLEAR;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.phase  = PH_CAPTURE;
          state_next = (req_type == REQ_STEP) ? S_RULE : S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.phase  = PH_EXEC;
        state_next = S_IDLE;
      end
      S_RULE: begin
        // a halted machine answers straight from the tape read
        cmd.phase  = PH_RULE;
        state_next = stat.halted ? S_IDLE : S_STEP;
      end
      S_STEP: begin
        cmd.phase  = PH_STEP;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// ===== rtl/btm_datapath.sv =====
// ----------------------------------------------------------------------------
// btm_datapath
// Tape memory, transition table, machine registers and result register.
// ----------------------------------------------------------------------------
module btm_datapath
  import btm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  input  req_t              request,
  input  logic              cfg_we,
  input  logic [CELL_W-1:0] cfg_wdata,
  output dp_stat_t          stat,
  output logic              done,
  output rsp_t              response
);

  typedef struct packed {
    logic                wsym;
    logic [MOVE_W-1:0]   move;
    logic [STATE_AW-1:0] next;
  } rule_t;

  localparam logic [CELL_W:0]  TAPE_LEN_X   = (CELL_W + 1)'(TAPE_LEN);
  localparam logic [STATE_W:0] NUM_STATES_X = (STATE_W + 1)'(NUM_STATES);

  function automatic logic [CELL_W-1:0] start_cell(input logic [CELL_W-1:0] hs);
    logic [CELL_W-1:0] pos;
    pos = hs;
    if ({1'b0, hs} >= TAPE_LEN_X) begin
      pos = CELL_W'(TAPE_LEN - 1);
    end
    return pos;
  endfunction

  // Architectural registers
  logic [CELL_W-1:0]   head_start;
  logic [STATE_AW-1:0] machine_state;
  logic [CELL_W-1:0]   head;
  logic                halted;
  logic [NUM_RULES-1:0] rule_valid;
  logic [TAPE_AW-1:0]  clear_addr;

  // Memories and their read registers
  rule_t rule_mem [NUM_RULES];
  logic  tape_mem [TAPE_LEN];
  rule_t rule_q;
  logic  rule_valid_q;
  logic  tape_q;
  logic  seen_q;
  req_t  req_q;

  // Next values and memory port controls
  logic [STATE_AW-1:0] machine_state_next;
  logic [CELL_W-1:0]   head_next;
  logic                halted_next;
  logic [STAT_W-1:0]   status_v;
  logic                seen_v;
  logic                finish;
  logic                tape_we;
  logic [TAPE_AW-1:0]  tape_wa;
  logic                tape_wd;
  logic                tape_re;
  logic [TAPE_AW-1:0]  tape_ra;
  logic                rule_we;
  logic [RULE_AW-1:0]  rule_wa;
  rule_t               rule_wd;
  logic                rule_re;
  logic [RULE_AW-1:0]  rule_ra;
  logic                cell_ok;
  logic                states_ok;

  assign stat.clear_last = (clear_addr == TAPE_AW'(TAPE_LEN - 1));
  assign stat.halted     = halted;

  assign cell_ok   = ({1'b0, req_q.cell_address} < TAPE_LEN_X);
  assign states_ok = ({1'b0, req_q.from_state} < NUM_STATES_X) &&
                     ({1'b0, req_q.to_state} < NUM_STATES_X);

  always_comb begin
    machine_state_next = machine_state;
    head_next          = head;
    halted_next        = halted;
    status_v           = ST_OK;
    seen_v             = 1'b0;
    finish             = 1'b0;
    tape_we            = 1'b0;
    tape_wa            = TAPE_AW'(head);
    tape_wd            = 1'b0;
    tape_re            = 1'b0;
    tape_ra            = TAPE_AW'(head);
    rule_we            = 1'b0;
    rule_wa            = {STATE_AW'(req_q.from_state), req_q.match_symbol};
    rule_wd            = '{wsym: req_q.write_symbol, move: req_q.move_dir,
                           next: STATE_AW'(req_q.to_state)};
    rule_re            = 1'b0;
    rule_ra            = {machine_state, tape_q};
    case (cmd.phase)
      PH_CLEAR: begin
        tape_we = 1'b1;
        tape_wa = clear_addr;
      end
      PH_CAPTURE: begin
        tape_re = 1'b1;
        if (request.req_type == REQ_READ) begin
          tape_ra = TAPE_AW'(request.cell_address);
        end
      end
      PH_EXEC: begin
        finish = 1'b1;
        case (req_q.req_type)
          REQ_ADD: begin
            if (!states_ok || rule_valid[rule_wa]) begin
              status_v = ST_DUP;
            end else begin
              rule_we = 1'b1;
            end
          end
          REQ_WRITE: begin
            tape_we = cell_ok;
            tape_wa = TAPE_AW'(req_q.cell_address);
            tape_wd = req_q.cell_value;
          end
          REQ_READ: begin
            seen_v = cell_ok & tape_q;
          end
          REQ_RESTART: begin
            machine_state_next = '0;
            head_next          = start_cell(head_start);
            halted_next        = 1'b0;
          end
          default: begin
          end
        endcase
      end
      PH_RULE: begin
        seen_v = tape_q;
        if (halted) begin
          finish   = 1'b1;
          status_v = ST_HALT;
        end else begin
          rule_re = 1'b1;
        end
      end
      PH_STEP: begin
        finish = 1'b1;
        seen_v = seen_q;
        if (!rule_valid_q) begin
          halted_next = 1'b1;
          status_v    = ST_HALT;
        end else begin
          tape_we            = 1'b1;
          tape_wd            = rule_q.wsym;
          machine_state_next = rule_q.next;
          if (rule_q.move == MOVE_LEFT) begin
            if (head == '0) begin
              halted_next = 1'b1;
              status_v    = ST_EDGE;
            end else begin
              head_next = head - CELL_W'(1);
            end
          end else if (rule_q.move == MOVE_RIGHT) begin
            if (({1'b0, head} + (CELL_W + 1)'(1)) >= TAPE_LEN_X) begin
              halted_next = 1'b1;
              status_v    = ST_EDGE;
            end else begin
              head_next = head + CELL_W'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_start    <= HEAD_START_RST;
      machine_state <= '0;
      head          <= start_cell(HEAD_START_RST);
      halted        <= 1'b0;
      rule_valid    <= '0;
      clear_addr    <= '0;
      done          <= 1'b0;
    end else begin
      if (cfg_we) begin
        head_start <= cfg_wdata;
      end
      machine_state <= machine_state_next;
      head          <= head_next;
      halted        <= halted_next;
      if (rule_we) begin
        rule_valid[rule_wa] <= 1'b1;
      end
      if (cmd.phase == PH_CLEAR) begin
        clear_addr <= clear_addr + TAPE_AW'(1);
      end
      done <= finish;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.phase == PH_CAPTURE) begin
      req_q <= request;
    end
    if (rule_re) begin
      rule_q       <= rule_mem[rule_ra];
      rule_valid_q <= rule_valid[rule_ra];
      seen_q       <= tape_q;
    end
    if (finish) begin
      response.status        <= status_v;
      response.current_state <= STATE_W'(machine_state_next);
      response.head_position <= head_next;
      response.seen_symbol   <= seen_v;
      response.is_halted     <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rule_we) begin
      rule_mem[rule_wa] <= rule_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[tape_wa] <= tape_wd;
    end
    if (tape_re) begin
      tape_q <= tape_mem[tape_ra];
    end
  end

endmodule

// ===== rtl/binary_turing_machine_step_core.sv =====
// ----------------------------------------------------------------------------
// binary_turing_machine_step_core
// Two-symbol Turing machine engine with a bounded one-bit tape.
// ----------------------------------------------------------------------------
// Raise start with a request while busy is low; the transaction is taken at
// that clock edge. Every transaction returns exactly one response, shown on
// response for a single cycle while done is high. The response cannot be held
// off: capture it in that cycle. After reset, busy stays high while the tape
// is swept to zero, one cell per cycle; head_start writes are taken during
// that pass and at any other time.
//
// Phases of each transaction, from accept edge to done:
//   add, tape write, tape read, restart, unknown codes: capture, then execute;
//   step: tape read, then table read, then tape write and update;
//   a step on a halted machine ends after the tape read.
// The tape memory, with one write port and a registered read port, sets the
// step sequence, since each step reads the cell the previous step may have written.
// busy drops in the cycle that done rises, so a new transaction may be
// started while the previous response is still shown.
//
// A head_start write takes effect at the next restart. Adds are allowed while
// the machine runs and apply to the next step.
// ----------------------------------------------------------------------------
module binary_turing_machine_step_core
  import btm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_t              request,
  input  logic              cfg_we,
  input  logic [CELL_W-1:0] cfg_wdata,
  output logic              done,
  output rsp_t              response
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence the clearing pass and the phases of each transaction
  btm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (request.req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Hold tape, transition table and machine registers; build the response
  btm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .done      (done),
    .response  (response)
  );

endmodule
